FILE: design/sack_pkg.sv
// Shared types and constants for the selective ack tracker.
package sack_pkg;

  localparam int ID_W        = 32;
  localparam int GAP_W       = 5;
  localparam int STATUS_W    = 2;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  localparam logic [GAP_W-1:0] GAP_RESET = 5'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STALE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OOW   = 2'd3;

  localparam logic KIND_RESEND  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Access to the mark store: one read and one write per cycle.
  typedef struct packed {
    logic            rd_en;
    logic [ID_W-1:0] rd_id;
    logic            wr_en;
    logic [ID_W-1:0] wr_id;
  } sack_mreq_t;

endpackage

FILE: design/sack_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module sack_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/sack_mark_store.sv
// Ack mark store: id tags in RAM, indexed by id modulo depth, with valid bits.
module sack_mark_store #(
  parameter int WINDOW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sack_pkg::sack_mreq_t req,
  output logic                 hit
);
  import sack_pkg::*;

  localparam int AW    = $clog2(WINDOW);
  localparam int DEPTH = 1 << AW;

  logic [DEPTH-1:0] valid_r;
  logic             rd_valid_r;
  logic [ID_W-1:0]  rd_id_r;
  logic [ID_W-1:0]  rd_tag;

  sack_ram #(
    .WIDTH (ID_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_id[AW-1:0]),
    .wr_data (req.wr_id),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_id[AW-1:0]),
    .rd_data (rd_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_id[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_valid_r <= valid_r[req.rd_id[AW-1:0]];
      rd_id_r    <= req.rd_id;
    end
  end

  // An entry counts only if it holds exactly the id asked for; older ids
  // that alias to the same slot have long been passed by the point.
  assign hit = rd_valid_r && (rd_tag == rd_id_r);

endmodule

FILE: design/selective_ack_fast_resend_tracker.sv
// Top level: ack checking, cumulative walk and gap scan over the mark store.
// Each ack is checked against the mark store; an accepted one walks the cumulative point
//   over marked ids and, when the ack leads the resend mark by more than the gap, scans the
//   ids between for holes; each probe of the mark store is a registered RAM read.
// One ack at a time: a new ack is taken only once the summary item of the last is loaded.
// Reset (rst_n low, synchronous) clears point, resend mark, gap (to 2) and mark valid bits.
module selective_ack_fast_resend_tracker #(
  parameter int WINDOW = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sack_pkg::ID_W-1:0]       in_acked_id,
  input  logic [sack_pkg::ID_W-1:0]       in_peer_cumulative,
  input  logic [sack_pkg::ID_W-1:0]       in_next_send_id,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sack_pkg::GAP_W-1:0]      cfg_fast_resend_gap,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_item_kind,
  output logic [sack_pkg::ID_W-1:0]       out_resend_seq,
  output logic [sack_pkg::STATUS_W-1:0]   out_ack_status,
  output logic [sack_pkg::ID_W-1:0]       out_cumulative_point,
  output logic                            out_last_item
);
  import sack_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_WRD  = 3'd2;
  localparam logic [2:0] S_WCHK = 3'd3;
  localparam logic [2:0] S_RSET = 3'd4;
  localparam logic [2:0] S_SRD  = 3'd5;
  localparam logic [2:0] S_SCHK = 3'd6;
  localparam logic [2:0] S_SUM  = 3'd7;

  localparam logic [ID_W-1:0]  WIN_ID = ID_W'(WINDOW);
  localparam logic [ID_W-1:0]  ID_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_RESULTS - 1);

  logic [2:0]          state_r, state_nxt;
  logic [ID_W-1:0]     cum_r, cum_nxt;
  logic [ID_W-1:0]     rm_r, rm_nxt;
  logic [GAP_W-1:0]    gap_r;
  logic [ID_W-1:0]     ack_r, una_r, nsi_r;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]     out_seq_r, out_seq_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_cum_r, out_cum_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_load;

  sack_mreq_t          mreq;
  logic                hit;

  logic                in_acc;
  logic                out_free;
  logic                stale, oow;
  logic [ID_W-1:0]     rm_eff;
  logic [ID_W:0]       lead_lim;

  sack_mark_store #(
    .WINDOW (WINDOW)
  ) u_marks (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .hit   (hit)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  assign stale    = (ack_r <= cum_r) || (ack_r > nsi_r);
  assign oow      = (ack_r - cum_r) > WIN_ID;
  assign rm_eff   = (rm_r < cum_r) ? cum_r : rm_r;
  assign lead_lim = {1'b0, rm_eff} + {{(ID_W + 1 - GAP_W){1'b0}}, gap_r};

  always_comb begin
    state_nxt      = state_r;
    cum_nxt        = cum_r;
    rm_nxt         = rm_r;
    id_nxt         = id_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    mreq           = '0;
    out_load       = 1'b0;
    out_kind_nxt   = KIND_SUMMARY;
    out_seq_nxt    = '0;
    out_status_nxt = status_r;
    out_cum_nxt    = cum_r;
    out_last_nxt   = 1'b1;

    case (state_r)
      S_IDLE: begin
        mreq.rd_en = in_acc;
        mreq.rd_id = in_acked_id;
        if (in_acc) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (stale) begin
          status_nxt = ST_STALE;
          state_nxt  = S_SUM;
        end else if (oow) begin
          status_nxt = ST_OOW;
          state_nxt  = S_SUM;
        end else if (hit) begin
          status_nxt = ST_DUP;
          state_nxt  = S_SUM;
        end else begin
          status_nxt = ST_OK;
          mreq.wr_en = 1'b1;
          mreq.wr_id = ack_r;
          // jump to the peer point; marks at or below it simply drop out
          if (una_r > cum_r) begin
            cum_nxt = una_r;
          end
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        if (cum_r == ID_MAX) begin
          state_nxt = S_RSET;
        end else begin
          mreq.rd_en = 1'b1;
          mreq.rd_id = cum_r + 1'b1;
          state_nxt  = S_WCHK;
        end
      end
      S_WCHK: begin
        if (hit) begin
          cum_nxt   = cum_r + 1'b1;
          state_nxt = S_WRD;
        end else begin
          state_nxt = S_RSET;
        end
      end
      S_RSET: begin
        if ({1'b0, ack_r} > lead_lim) begin
          rm_nxt    = ack_r;
          id_nxt    = rm_eff + 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_SRD;
        end else begin
          rm_nxt    = rm_eff;
          state_nxt = S_SUM;
        end
      end
      S_SRD: begin
        // stop at the ack itself or once the request cap is reached
        if ((id_r == ack_r) || (cnt_r == CNT_CAP)) begin
          state_nxt = S_SUM;
        end else begin
          mreq.rd_en = 1'b1;
          mreq.rd_id = id_r;
          state_nxt  = S_SCHK;
        end
      end
      S_SCHK: begin
        if (hit) begin
          id_nxt    = id_r + 1'b1;
          state_nxt = S_SRD;
        end else if (out_free) begin
          out_load       = 1'b1;
          out_kind_nxt   = KIND_RESEND;
          out_seq_nxt    = id_r;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b0;
          cnt_nxt        = cnt_r + 1'b1;
          id_nxt         = id_r + 1'b1;
          state_nxt      = S_SRD;
        end
      end
      S_SUM: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cum_r       <= '0;
      rm_r        <= '0;
      gap_r       <= GAP_RESET;
      cnt_r       <= '0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cum_r       <= cum_nxt;
      rm_r        <= rm_nxt;
      cnt_r       <= cnt_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        gap_r <= cfg_fast_resend_gap;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    if (in_acc) begin
      ack_r <= in_acked_id;
      // an illegal peer point counts as zero
      una_r <= (in_peer_cumulative > in_next_send_id) ? '0 : in_peer_cumulative;
      nsi_r <= in_next_send_id;
    end
    if (out_load) begin
      out_kind_r   <= out_kind_nxt;
      out_seq_r    <= out_seq_nxt;
      out_status_r <= out_status_nxt;
      out_cum_r    <= out_cum_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_item_kind        = out_kind_r;
  assign out_resend_seq       = out_seq_r;
  assign out_ack_status       = out_status_r;
  assign out_cumulative_point = out_cum_r;
  assign out_last_item        = out_last_r;

  a_point_monotonic : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cum_r >= $past(cum_r))
    else $error("cumulative point moved back");

  a_resend_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_RESEND) |->
      (out_status_r == ST_OK && !out_last_r))
    else $error("resend item with status or last flag");

  a_resend_cap : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCHK) |-> (cnt_r != CNT_CAP))
    else $error("resend scan ran past the request cap");

  a_scan_below_ack : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCHK) |-> (id_r < ack_r))
    else $error("gap scan reached the acked id");

endmodule

FILE: verif/sack_tb_pkg.sv
// Result type and window predictor with result scoreboard for the ack tracker bench.
`timescale 1ns / 100ps
package sack_tb_pkg;
  import sack_pkg::*;

  localparam int ACK_WINDOW = 32;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic                kind;
    logic [ID_W-1:0]     seq;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     point;
    logic                last;
  } tracker_result_t;

  class ack_window_predictor;
    logic [GAP_W-1:0]      resend_gap;
    logic [ID_W-1:0]       cum_point;
    logic [ID_W-1:0]       resend_mark;
    logic [ACK_WINDOW-1:0] marks;
    tracker_result_t       expected_results[int];
    int                    exp_head;
    int                    exp_tail;
    int                    errors;

    function new();
      resend_gap  = GAP_RESET;
      cum_point   = '0;
      resend_mark = '0;
      marks       = '0;
      exp_head    = 0;
      exp_tail    = 0;
      errors      = 0;
    endfunction

    function int outstanding();
      return exp_tail - exp_head;
    endfunction

    function bit id_acked(longint unsigned id);
      longint unsigned k;
      if (id <= longint'(cum_point)) return 1'b1;
      k = id - cum_point - 1;
      if (k >= ACK_WINDOW) return 1'b0;
      return marks[int'(k)];
    endfunction

    function void shift_point(longint unsigned d);
      longint unsigned sum;
      if (d >= ACK_WINDOW) marks = '0;
      else marks = marks >> d;
      sum = longint'(cum_point) + d;
      cum_point = sum[ID_W-1:0];
    endfunction

    function void push_result(logic kind, logic [ID_W-1:0] seq, logic [STATUS_W-1:0] status,
                              logic last);
      tracker_result_t r;
      r.kind   = kind;
      r.seq    = seq;
      r.status = status;
      r.point  = cum_point;
      r.last   = last;
      expected_results[exp_tail] = r;
      exp_tail++;
    endfunction

    // Work out the resend requests and the summary that one accepted ack causes.
    function void take_ack(logic [ID_W-1:0] acked, logic [ID_W-1:0] peer,
                           logic [ID_W-1:0] next_send);
      longint unsigned     a;
      longint unsigned     u;
      longint unsigned     n;
      longint unsigned     c;
      longint unsigned     rm;
      longint unsigned     id;
      logic [STATUS_W-1:0] status;
      int                  resends;
      a       = acked;
      u       = peer;
      n       = next_send;
      c       = cum_point;
      status  = ST_OK;
      resends = 0;
      if (u > n) u = 0;
      if (a <= c || a > n) begin
        status = ST_STALE;
      end else if (a - c > ACK_WINDOW) begin
        status = ST_OOW;
      end else if (id_acked(a)) begin
        status = ST_DUP;
      end else begin
        marks[int'(a - c - 1)] = 1'b1;
        if (u > c) shift_point(u - c);
        while (marks[0] && cum_point != '1) shift_point(1);
        if (resend_mark < cum_point) resend_mark = cum_point;
        rm = resend_mark;
        if (a > rm + resend_gap) begin
          for (id = rm + 1; id < a; id++) begin
            if (!id_acked(id) && resends < MAX_RESULTS - 1) begin
              push_result(KIND_RESEND, id[ID_W-1:0], ST_OK, 1'b0);
              resends++;
            end
          end
          resend_mark = acked;
        end
      end
      push_result(KIND_SUMMARY, '0, status, 1'b1);
    endfunction

    function void check_result(tracker_result_t got);
      tracker_result_t want;
      if (exp_tail == exp_head) begin
        errors++;
        if (errors <= SHOWN_MISMATCHES)
          $display("%0t: unexpected result kind=%0d seq=%0h status=%0d point=%0h last=%0d",
                   $realtime, got.kind, got.seq, got.status, got.point, got.last);
        return;
      end
      want = expected_results[exp_head];
      expected_results.delete(exp_head);
      exp_head++;
      if (want.kind !== got.kind || want.seq !== got.seq || want.status !== got.status ||
          want.point !== got.point || want.last !== got.last) begin
        errors++;
        if (errors <= SHOWN_MISMATCHES)
          $display({"%0t: mismatch exp kind=%0d seq=%0h status=%0d point=%0h last=%0d",
                    " | got kind=%0d seq=%0h status=%0d point=%0h last=%0d"},
                   $realtime, want.kind, want.seq, want.status, want.point, want.last,
                   got.kind, got.seq, got.status, got.point, got.last);
      end
    endfunction
  endclass

endpackage

FILE: verif/tb_top.sv
// Top-level bench for the selective ack tracker: stimulus, handshakes and verdict.
`timescale 1ns / 100ps
module tb_top;
  import sack_pkg::*;
  import sack_tb_pkg::*;

  localparam int IDLE_PCT    = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ACKS  = 50;
  localparam int NUM_PHASES  = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 150;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ID_W-1:0]     in_acked_id;
  logic [ID_W-1:0]     in_peer_cumulative;
  logic [ID_W-1:0]     in_next_send_id;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [GAP_W-1:0]    cfg_fast_resend_gap;
  logic                out_valid;
  logic                out_ready;
  logic                out_item_kind;
  logic [ID_W-1:0]     out_resend_seq;
  logic [STATUS_W-1:0] out_ack_status;
  logic [ID_W-1:0]     out_cumulative_point;
  logic                out_last_item;

  ack_window_predictor tracker;
  bit                  quiet;
  bit                  hold_req;
  int                  cycle_count;

  always #2 clk = ~clk;

  selective_ack_fast_resend_tracker #(.WINDOW(ACK_WINDOW)) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_acked_id         (in_acked_id),
    .in_peer_cumulative  (in_peer_cumulative),
    .in_next_send_id     (in_next_send_id),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_fast_resend_gap (cfg_fast_resend_gap),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_item_kind       (out_item_kind),
    .out_resend_seq      (out_resend_seq),
    .out_ack_status      (out_ack_status),
    .out_cumulative_point(out_cumulative_point),
    .out_last_item       (out_last_item)
  );

  always @(posedge clk) begin
    tracker_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.kind   = out_item_kind;
      got.seq    = out_resend_seq;
      got.status = out_ack_status;
      got.point  = out_cumulative_point;
      got.last   = out_last_item;
      tracker.check_result(got);
    end
  end

  // Result side: random stalls, one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Called just after a falling edge; returns just after a falling edge.
  task automatic offer_ack(input logic [ID_W-1:0] a, input logic [ID_W-1:0] p,
                           input logic [ID_W-1:0] n);
    if (!quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid           <= 1'b1;
    in_acked_id        <= a;
    in_peer_cumulative <= p;
    in_next_send_id    <= n;
    do @(posedge clk); while (!in_ready);
    tracker.take_ack(a, p, n);
    @(negedge clk);
  endtask

  task automatic write_gap(input logic [GAP_W-1:0] g);
    cfg_valid           <= 1'b1;
    cfg_fast_resend_gap <= g;
    do @(posedge clk); while (!cfg_ready);
    tracker.resend_gap = g;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Mostly acks close to the current point with random holes, plus noise.
  function automatic void pick_ack(output logic [ID_W-1:0] a, output logic [ID_W-1:0] p,
                                   output logic [ID_W-1:0] n);
    longint unsigned c;
    longint unsigned a64;
    longint unsigned p64;
    longint unsigned n64;
    int              sel;
    c   = tracker.cum_point;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      a64 = $urandom;
      p64 = $urandom;
      n64 = $urandom;
    end else if (sel < 18) begin
      a64 = $urandom_range(tracker.cum_point, 0);
      p64 = $urandom_range(tracker.cum_point, 0);
      n64 = c + $urandom_range(0, 40);
    end else begin
      n64 = c + $urandom_range(1, 48);
      a64 = c + $urandom_range(1, 36);
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        p64 = $urandom_range(tracker.cum_point, 0);
      end else if (sel < 80) begin
        p64 = c + $urandom_range(0, 3);
      end else if (sel < 90) begin
        p64 = n64 + $urandom_range(1, 100);
      end else begin
        p64 = c + $urandom_range(ACK_WINDOW, 200);
        n64 = p64 + $urandom_range(0, 40);
      end
    end
    a = a64[ID_W-1:0];
    p = p64[ID_W-1:0];
    n = n64[ID_W-1:0];
  endfunction

  initial begin
    logic [ID_W-1:0]  a;
    logic [ID_W-1:0]  p;
    logic [ID_W-1:0]  n;
    logic [GAP_W-1:0] gaps[NUM_PHASES];
    longint unsigned  id;

    tracker             = new();
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_acked_id         = '0;
    in_peer_cumulative  = '0;
    in_next_send_id     = '0;
    cfg_valid           = 1'b0;
    cfg_fast_resend_gap = '0;
    quiet               = 1'b0;
    hold_req            = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part under the reset gap.
    offer_ack(32'd0, 32'd0, 32'd0);                      // stale at zero
    offer_ack(32'd5, 32'd0, 32'd4);                      // beyond sent
    offer_ack(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // out of window
    offer_ack(32'd33, 32'd0, 32'd100);                   // just outside the window
    offer_ack(32'd32, 32'hFFFF_FFFF, 32'd100);           // illegal peer point, full gap scan
    offer_ack(32'd32, 32'd0, 32'd100);                   // duplicate
    offer_ack(32'd3, 32'd0, 32'd100);
    offer_ack(32'd1, 32'd0, 32'd100);                    // walk over one mark
    offer_ack(32'd2, 32'd0, 32'd100);                    // walk over two marks
    offer_ack(32'd10, 32'd8, 32'd20);                    // small peer advance
    offer_ack(32'd40, 32'd60, 32'd100);                  // large peer jump clears marks
    offer_ack(32'd62, 32'd10, 32'd100);                  // point never moves back
    offer_ack(32'd66, 32'd0, 32'd100);                   // fast resend of holes
    offer_ack(32'd61, 32'd61, 32'd61);                   // ack equal to next send id
    offer_ack(32'd1, 32'd0, 32'hFFFF_FFFF);              // stale
    wait_idle(10);

    gaps[0] = 5'd31;
    gaps[1] = 5'd0;
    gaps[2] = 5'd1;
    gaps[3] = $urandom_range(0, 31);
    gaps[4] = 5'd16;
    gaps[5] = $urandom_range(0, 31);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_gap(gaps[ph]);
      quiet = (ph == 2);
      if (ph == 1) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ACKS; i++) begin
        pick_ack(a, p, n);
        offer_ack(a, p, n);
      end
      wait_idle(10);
    end
    quiet = 1'b0;

    // Top of the id space: cannot be left again, so it comes last.
    write_gap(5'd2);
    a = tracker.cum_point + 1;
    offer_ack(a, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    offer_ack(32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    for (id = 64'hFFFF_FFF1; id < 64'hFFFF_FFFF; id++)
      offer_ack(id[ID_W-1:0], 32'd0, 32'hFFFF_FFFF);
    offer_ack(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_ack($urandom, $urandom, $urandom);

    wait_idle(DRAIN_WAIT);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
